>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the line framer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is applied.
`define SLF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication on the same edge.
`define SLF_ASSERT_IMP(lbl, ante, cons, msg) \
    `SLF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> design/slf_pkg.sv
// ----------------------------------------------------------------------------
// slf_pkg
// Types and character codes shared by the line framer and its checker.
// ----------------------------------------------------------------------------
package slf_pkg;

    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 9;
    localparam int PAY_LEN_W  = 10;
    localparam int TIMEOUT_W  = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd80;
    localparam logic [TIMEOUT_W-1:0] TICKS_MAX     = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_STX   = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX   = 8'h03;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;

    typedef enum logic [OP_W-1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2,
        OP_TAKE = 2'd3
    } op_t;

    typedef struct packed {
        op_t               operation;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic                 payload_ready;
        logic [PAY_LEN_W-1:0] payload_length;
        logic [BYTE_W-1:0]    read_data;
        logic                 frame_closed;
    } out_item_t;

    typedef logic [TIMEOUT_W-1:0] cfg_word_t;

endpackage

>>> design/slf_chan_if.sv
// ----------------------------------------------------------------------------
// slf_chan_if
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
interface slf_chan_if #(
    parameter type PAYLOAD_T = logic
) ();

    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> design/slf_ram.sv
// ----------------------------------------------------------------------------
// slf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module slf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/stx_etx_line_framer_with_timeout.sv
// ----------------------------------------------------------------------------
// stx_etx_line_framer_with_timeout
// STX/ETX line framer: builds frames in one bank of a two-bank byte store,
// closes them on ETX/CR/LF or idle timeout and serves trimmed payload reads.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                           | width
//  req     | in  | operation, data_byte, read_index                  | 2+8+9
//  rsp     | out | payload_ready, payload_length, read_data, closed  | 1+10+8+1
//  cfg     | in  | idle_timeout_ms                                   | 16
//
//  One item per cycle sustained while rsp is not stalled; each result passes
//  the store read and then the output register before it is shown on rsp.
//  Frame bookkeeping lives in flops and is updated on the accept edge; the
//  byte store is written or read on that same edge.
//  A stalled rsp holds both stages; req.ready drops once both are full.
//  Reset clears control state and restores TIMEOUT_RESET; byte store is kept.
// ----------------------------------------------------------------------------
module stx_etx_line_framer_with_timeout #(
    parameter int MAX_FRAME_LEN = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    slf_chan_if.sink                             req,
    slf_chan_if.source                           rsp,
    slf_chan_if.sink                             cfg
);

    import slf_pkg::*;

    localparam int DEPTH  = 2 * MAX_FRAME_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(MAX_FRAME_LEN);
    localparam int LEN_W  = $clog2(MAX_FRAME_LEN + 1);

    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_FRAME_LEN);
    localparam logic [ADDR_W-1:0] BANK1_OFS = ADDR_W'(MAX_FRAME_LEN);

    // frame and payload bookkeeping
    logic                 bank_reg,    bank_next;
    logic [LEN_W-1:0]     blen_reg,    blen_next;
    logic [POS_W-1:0]     first_reg,   first_next;
    logic [POS_W-1:0]     last_reg,    last_next;
    logic                 has_ns_reg,  has_ns_next;
    logic [TIMEOUT_W-1:0] idle_reg,    idle_next;
    logic                 seen_reg,    seen_next;
    logic                 rdy_reg,     rdy_next;
    logic [ADDR_W-1:0]    rstart_reg,  rstart_next;
    logic [LEN_W-1:0]     rlen_reg,    rlen_next;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // pipeline
    logic                 s1_valid_reg;
    logic                 s1_ready_reg;
    logic [PAY_LEN_W-1:0] s1_len_reg;
    logic                 s1_closed_reg;
    logic                 s1_hit_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 accept;
    logic                 advance;
    logic                 closed;
    logic                 read_hit;
    logic                 do_close;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [BYTE_W-1:0]    mem_rdata;
    logic [ADDR_W-1:0]    bank_base;
    logic [POS_W-1:0]     pos;
    logic [TIMEOUT_W-1:0] idle_inc;
    logic                 printable;
    in_item_t             it;

    assign it      = req.payload;
    assign advance = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign accept  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign bank_base = bank_reg ? BANK1_OFS : '0;
    assign pos       = blen_reg[POS_W-1:0];
    assign idle_inc  = (idle_reg == TICKS_MAX) ? idle_reg : idle_reg + 1'b1;
    assign printable = (it.data_byte >= CH_SPACE) && (it.data_byte <= CH_TILDE);

    assign read_hit  = rdy_reg && (LEN_W'(it.read_index) < rlen_reg)
                       && ({1'b0, it.read_index} < {1'b0, IDX_W'(rlen_reg)}
                           || LEN_W > IDX_W);
    assign mem_raddr = rstart_reg + ADDR_W'(it.read_index);
    assign mem_waddr = bank_base + ADDR_W'(pos);

    always_comb
    begin
        bank_next   = bank_reg;
        blen_next   = blen_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        has_ns_next = has_ns_reg;
        idle_next   = idle_reg;
        seen_next   = seen_reg;
        rdy_next    = rdy_reg;
        rstart_next = rstart_reg;
        rlen_next   = rlen_reg;
        do_close    = 1'b0;
        mem_we      = 1'b0;

        if (accept)
        begin
            case (it.operation)
                OP_BYTE:
                begin
                    idle_next = '0;
                    seen_next = 1'b1;
                    if (it.data_byte == CH_STX)
                    begin
                        blen_next   = '0;
                        first_next  = '0;
                        last_next   = '0;
                        has_ns_next = 1'b0;
                    end
                    else if (it.data_byte inside {CH_ETX, CH_LF, CH_CR})
                    begin
                        do_close = (blen_reg != '0);
                    end
                    else if (printable && (blen_reg < LEN_MAX))
                    begin
                        mem_we    = 1'b1;
                        blen_next = blen_reg + 1'b1;
                        if (it.data_byte != CH_SPACE)
                        begin
                            if (!has_ns_reg)
                            begin
                                first_next  = pos;
                                has_ns_next = 1'b1;
                            end
                            last_next = pos;
                        end
                    end
                end
                OP_TICK:
                begin
                    idle_next = idle_inc;
                    do_close  = (blen_reg != '0) && seen_reg && (idle_inc > timeout_reg);
                end
                OP_TAKE:
                begin
                    rdy_next  = 1'b0;
                    rlen_next = '0;
                end
                default:
                begin
                end
            endcase

            if (do_close)
            begin
                if (has_ns_reg)
                begin
                    rstart_next = bank_base + ADDR_W'(first_reg);
                    rlen_next   = LEN_W'(last_reg) - LEN_W'(first_reg) + 1'b1;
                end
                else
                begin
                    rstart_next = bank_base;
                    rlen_next   = '0;
                end
                rdy_next    = 1'b1;
                bank_next   = !bank_reg;
                blen_next   = '0;
                first_next  = '0;
                last_next   = '0;
                has_ns_next = 1'b0;
            end
        end
    end

    assign closed = do_close;

    slf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (it.data_byte),
        .re    (accept && (it.operation == OP_READ)),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg      <= 1'b0;
            blen_reg      <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            has_ns_reg    <= 1'b0;
            idle_reg      <= '0;
            seen_reg      <= 1'b0;
            rdy_reg       <= 1'b0;
            rstart_reg    <= '0;
            rlen_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bank_reg   <= bank_next;
            blen_reg   <= blen_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            has_ns_reg <= has_ns_next;
            idle_reg   <= idle_next;
            seen_reg   <= seen_next;
            rdy_reg    <= rdy_next;
            rstart_reg <= rstart_next;
            rlen_reg   <= rlen_next;
            if (cfg.valid && cfg.ready)
            begin
                timeout_reg <= cfg.payload;
            end
            if (req.ready)
            begin
                s1_valid_reg <= accept;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload side, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ready_reg  <= rdy_next;
            s1_len_reg    <= rdy_next ? PAY_LEN_W'(rlen_next) : '0;
            s1_closed_reg <= closed;
            s1_hit_reg    <= (it.operation == OP_READ) && read_hit;
        end
        if (advance && s1_valid_reg)
        begin
            out_reg.payload_ready  <= s1_ready_reg;
            out_reg.payload_length <= s1_len_reg;
            out_reg.read_data      <= s1_hit_reg ? mem_rdata : '0;
            out_reg.frame_closed   <= s1_closed_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

endmodule

>>> design/slf_checker.sv
// ----------------------------------------------------------------------------
// slf_checker
// Port-level checks on the line framer's result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input slf_pkg::out_item_t rsp_payload
);

    import slf_pkg::*;

    `SLF_ASSERT_IMP(a_hold_valid, rsp_valid && !rsp_ready, ##1 rsp_valid, "result dropped while stalled")
    `SLF_ASSERT_IMP(a_hold_payload, rsp_valid && !rsp_ready, ##1 $stable(rsp_payload), "result changed while stalled")
    `SLF_ASSERT_IMP(a_close_ready, rsp_valid && rsp_payload.frame_closed, rsp_payload.payload_ready, "closed frame without ready payload")
    `SLF_ASSERT_IMP(a_empty_len, rsp_valid && !rsp_payload.payload_ready, rsp_payload.payload_length == '0, "length shown with no payload")
    `SLF_ASSERT_IMP(a_read_ready, rsp_valid && (rsp_payload.read_data != '0), rsp_payload.payload_ready, "read data with no payload")

endmodule

bind stx_etx_line_framer_with_timeout slf_checker u_slf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
